[rtl/ftf_pkg.sv]
package ftf_pkg;

	// Table and key geometry
	localparam int FLOW_ENTRIES_DEF = 64;
	localparam int IDX_W            = 6;
	localparam int KEY_WORDS        = 5;
	localparam int LEN_W            = 16;

	// Header field constants
	localparam logic [11:0] VID_MASK     = 12'h0fff;
	localparam logic [3:0]  IHL_MASK     = 4'hF;
	localparam logic [7:0]  V6_HDR_LEN   = 8'd40;
	localparam logic [15:0] ETH_TAG_Q    = 16'h8100;
	localparam logic [15:0] ETH_TAG_AD   = 16'h88A8;
	localparam logic [15:0] ETH_IPV4     = 16'h0800;
	localparam logic [15:0] ETH_IPV6     = 16'h86DD;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [63:0] WORD4_MASK   = 64'h03FF_FFFF_FFFF_FFFF;

	// Verdict codes
	localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [1:0] VERDICT_DROP   = 2'd1;
	localparam logic [1:0] VERDICT_TRUNC  = 2'd2;

	typedef enum logic [1:0] {
		REQ_PKT = 2'd0,
		REQ_WR  = 2'd1,
		REQ_RD  = 2'd2,
		REQ_INV = 2'd3
	} req_t;

	typedef logic [KEY_WORDS-1:0][63:0] key_t;

	// Table maintenance broadcast to every cell
	typedef struct packed {
		logic             wr;
		logic             inv;
		logic [IDX_W-1:0] idx;
		logic [2:0]       sel;
		logic [63:0]      word;
	} cmd_t;

	// Operation held steady while a token walks the chain
	typedef struct packed {
		logic             lookup;
		logic             read;
		logic [1:0]       verdict;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		key_t             key;
	} job_t;

	// Token handed from cell to cell
	typedef struct packed {
		logic             go;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [63:0]      pkt;
		logic [63:0]      byt;
	} token_t;

	// Frame decision from the header parser
	typedef struct packed {
		logic             lookup;
		logic [1:0]       verdict;
		logic [LEN_W-1:0] len;
		key_t             key;
	} pdec_t;

endpackage

[rtl/ftf_parser.sv]
module ftf_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           last,
	input  logic [7:0]     data_byte,
	input  logic [11:0]    outer_vid,
	output ftf_pkg::pdec_t dec
);

	logic [15:0]      pos_q;
	logic [15:0]      ek_q, ek_n;
	logic [11:0]      iv_q, iv_n;
	logic [7:0]       to_q, to_n;
	logic [7:0]       pr_q, pr_n;
	logic [3:0][31:0] src_q, src_n;
	logic [3:0][31:0] dst_q, dst_n;
	logic [31:0]      pp_q, pp_n;
	logic             tg_q, tg_n;

	logic [15:0] nh0;
	logic [15:0] r;
	logic [15:0] rs6, rd6;
	logic [1:0]  k6s, k6d;
	logic [15:0] len;
	logic [16:0] len17, nh;
	logic        tcp_udp;
	logic        v6;
	logic        lookup;
	logic [1:0]  verdict;

	assign nh0 = tg_q ? 16'd18 : 16'd14;
	assign r   = pos_q - nh0;
	assign rs6 = r - 16'd8;
	assign rd6 = r - 16'd24;
	assign k6s = rs6[3:2];
	assign k6d = rd6[3:2];

	// Take one header byte into the next-state fields
	always_comb begin
		tg_n  = tg_q;
		ek_n  = ek_q;
		iv_n  = iv_q;
		to_n  = to_q;
		pr_n  = pr_q;
		src_n = src_q;
		dst_n = dst_q;
		pp_n  = pp_q;
		if (pos_q == 16'd12) begin
			ek_n = {data_byte, 8'h00};
		end else if (pos_q == 16'd13) begin
			ek_n = {ek_q[15:8], data_byte};
			if (ek_n == ftf_pkg::ETH_TAG_Q || ek_n == ftf_pkg::ETH_TAG_AD) begin
				tg_n = 1'b1;
			end
		end else if (tg_q && pos_q == 16'd14) begin
			iv_n = ftf_pkg::VID_MASK & 12'({data_byte, 8'h00});
		end else if (tg_q && pos_q == 16'd15) begin
			iv_n = ftf_pkg::VID_MASK & (iv_q | {4'h0, data_byte});
		end else if (tg_q && pos_q == 16'd16) begin
			ek_n = {data_byte, 8'h00};
		end else if (tg_q && pos_q == 16'd17) begin
			ek_n = {ek_q[15:8], data_byte};
		end

		if (pos_q >= nh0) begin
			if (ek_n == ftf_pkg::ETH_IPV4) begin
				if (r == 16'd0) begin
					to_n = {2'b00, data_byte[3:0] & ftf_pkg::IHL_MASK, 2'b00};
				end
				if (r == 16'd9) begin
					pr_n = data_byte;
				end
				if (r >= 16'd12 && r < 16'd16) begin
					src_n[3] = {src_q[3][23:0], data_byte};
				end
				if (r >= 16'd16 && r < 16'd20) begin
					dst_n[3] = {dst_q[3][23:0], data_byte};
				end
				if (r >= 16'(to_n) && r < 16'(to_n) + 16'd4) begin
					pp_n = {pp_q[23:0], data_byte};
				end
			end else if (ek_n == ftf_pkg::ETH_IPV6) begin
				if (r == 16'd0) begin
					to_n = ftf_pkg::V6_HDR_LEN;
				end
				if (r == 16'd6) begin
					pr_n = data_byte;
				end
				if (r >= 16'd8 && r < 16'd24) begin
					src_n[k6s] = {src_q[k6s][23:0], data_byte};
				end
				if (r >= 16'd24 && r < 16'd40) begin
					dst_n[k6d] = {dst_q[k6d][23:0], data_byte};
				end
				if (r >= 16'(ftf_pkg::V6_HDR_LEN) && r < 16'(ftf_pkg::V6_HDR_LEN) + 16'd4) begin
					pp_n = {pp_q[23:0], data_byte};
				end
			end
		end
	end

	// Frame length saturates at the top of the position range
	assign len     = (pos_q == 16'hFFFF) ? 16'hFFFF : pos_q + 16'd1;
	assign len17   = {1'b0, len};
	assign nh      = tg_n ? 17'd18 : 17'd14;
	assign tcp_udp = (pr_n == ftf_pkg::PROTO_TCP) || (pr_n == ftf_pkg::PROTO_UDP);

	// Decide the verdict as if this byte ends the frame
	always_comb begin
		lookup  = 1'b0;
		verdict = ftf_pkg::VERDICT_ACCEPT;
		v6      = 1'b0;
		if (len17 < nh) begin
			verdict = ftf_pkg::VERDICT_TRUNC;
		end else if (ek_n == ftf_pkg::ETH_IPV4) begin
			if (len17 < nh + 17'd10) begin
				verdict = ftf_pkg::VERDICT_TRUNC;
			end else if (!tcp_udp) begin
				verdict = ftf_pkg::VERDICT_ACCEPT;
			end else if (len17 < nh + 17'd20 || len17 < nh + 17'(to_n) + 17'd4) begin
				verdict = ftf_pkg::VERDICT_TRUNC;
			end else begin
				lookup = 1'b1;
			end
		end else if (ek_n == ftf_pkg::ETH_IPV6) begin
			if (len17 < nh + 17'd7) begin
				verdict = ftf_pkg::VERDICT_TRUNC;
			end else if (!tcp_udp) begin
				verdict = ftf_pkg::VERDICT_ACCEPT;
			end else if (len17 < nh + 17'(ftf_pkg::V6_HDR_LEN) + 17'd4) begin
				verdict = ftf_pkg::VERDICT_TRUNC;
			end else begin
				lookup = 1'b1;
				v6     = 1'b1;
			end
		end
	end

	// Assemble the lookup key
	assign dec.lookup  = lookup;
	assign dec.verdict = verdict;
	assign dec.len     = len;
	assign dec.key[0]  = {src_n[0], src_n[1]};
	assign dec.key[1]  = {src_n[2], src_n[3]};
	assign dec.key[2]  = {dst_n[0], dst_n[1]};
	assign dec.key[3]  = {dst_n[2], dst_n[3]};
	assign dec.key[4]  = {6'b0, v6, iv_n & ftf_pkg::VID_MASK, outer_vid & ftf_pkg::VID_MASK,
		pr_n == ftf_pkg::PROTO_TCP, pp_n};

	// Advance per accepted byte, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ek_q  <= '0;
			iv_q  <= '0;
			to_q  <= '0;
			pr_q  <= '0;
			src_q <= '0;
			dst_q <= '0;
			pp_q  <= '0;
			tg_q  <= 1'b0;
		end else if (en) begin
			if (last) begin
				pos_q <= '0;
				ek_q  <= '0;
				iv_q  <= '0;
				to_q  <= '0;
				pr_q  <= '0;
				src_q <= '0;
				dst_q <= '0;
				pp_q  <= '0;
				tg_q  <= 1'b0;
			end else begin
				pos_q <= len;
				ek_q  <= ek_n;
				iv_q  <= iv_n;
				to_q  <= to_n;
				pr_q  <= pr_n;
				src_q <= src_n;
				dst_q <= dst_n;
				pp_q  <= pp_n;
				tg_q  <= tg_n;
			end
		end
	end

endmodule

[rtl/ftf_cell.sv]
module ftf_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ftf_pkg::cmd_t   cmd,
	input  ftf_pkg::job_t   job,
	input  ftf_pkg::token_t tok_in,
	output ftf_pkg::token_t tok_out
);

	localparam int              IW          = ftf_pkg::IDX_W;
	localparam bit              ADDRESSABLE = (IDX < (1 << IW));
	localparam logic [IW-1:0]   MY_IDX      = IW'(IDX);
	localparam logic [2:0]      LAST_SEL    = 3'(ftf_pkg::KEY_WORDS - 1);

	ftf_pkg::key_t   key_q;
	logic            valid_q;
	logic [63:0]     pkt_q;
	logic [63:0]     byt_q;
	ftf_pkg::token_t tok_q;
	ftf_pkg::token_t tok_n;

	logic mine;
	logic sel_ok;
	logic hit;
	logic rd;

	assign mine   = ADDRESSABLE && (cmd.idx == MY_IDX);
	assign sel_ok = cmd.sel <= LAST_SEL;
	assign hit    = tok_in.go && job.lookup && !tok_in.hit && valid_q && (key_q == job.key);
	assign rd     = tok_in.go && job.read && ADDRESSABLE && (job.idx == MY_IDX);

	// Store key words; top word keeps its unused bits at zero
	always_ff @(posedge clk) begin
		if (cmd.wr && mine && sel_ok) begin
			key_q[cmd.sel] <= (cmd.sel == LAST_SEL) ? (cmd.word & ftf_pkg::WORD4_MASK) : cmd.word;
		end
	end

	// Valid bit and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pkt_q   <= '0;
			byt_q   <= '0;
		end else if (cmd.wr && mine && cmd.sel == LAST_SEL) begin
			valid_q <= 1'b1;
			pkt_q   <= '0;
			byt_q   <= '0;
		end else if (cmd.inv && mine) begin
			valid_q <= 1'b0;
		end else if (hit) begin
			pkt_q <= pkt_q + 64'd1;
			byt_q <= byt_q + 64'(job.len);
		end
	end

	// Mark a hit or a read-back on the passing token
	always_comb begin
		tok_n = tok_in;
		if (hit) begin
			tok_n.hit     = 1'b1;
			tok_n.hit_idx = MY_IDX;
		end
		if (rd) begin
			tok_n.pkt = pkt_q;
			tok_n.byt = byt_q;
		end
	end

	// Hand the token on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_n;
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/flow_bypass_table_filter_core.sv]
// Flow bypass filter: parses Ethernet frames one byte per word, forms a
// five-tuple key (with both VLAN IDs) and matches it against a table held in
// a row of FLOW_ENTRIES cells. Frame bytes that are not the last one are taken
// every cycle while no token walks and the output register is not held. The
// last byte of a frame and a counter read each launch a token that walks the
// cell row one cell per cycle; the input stalls until the token leaves the
// row, and its result is then registered at the output. Key writes and
// invalidates launch no token and go to all cells at once.
// Lowest matching entry wins.
module flow_bypass_table_filter_core #(
	parameter int FLOW_ENTRIES = ftf_pkg::FLOW_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// data_byte[7:0], outer_vlan_id[19:8], entry_index[25:20],
	// key_word_select[28:26], key_word[92:29], zero pad[95:93]
	input  logic [95:0]  s_tdata,
	input  logic [1:0]   s_tuser,   // req_type[1:0]
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// verdict[1:0], hit_index[7:2], packet_count[71:8], byte_count[135:72]
	output logic [135:0] m_tdata,
	output logic         m_tuser    // result_kind
);

	ftf_pkg::req_t   req;
	ftf_pkg::pdec_t  dec;
	ftf_pkg::cmd_t   cmd;
	ftf_pkg::job_t   job_q;
	ftf_pkg::token_t tok [FLOW_ENTRIES+1];

	logic        accept;
	logic        launch;
	logic        done;
	logic        go_q;
	logic        busy_q;
	logic        out_valid_q;
	logic        out_kind_q;
	logic [1:0]  out_verdict_q;
	logic [5:0]  out_hit_q;
	logic [63:0] out_pkt_q;
	logic [63:0] out_byt_q;

	assign req      = ftf_pkg::req_t'(s_tuser);
	assign s_tready = !busy_q && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign launch   = accept && ((req == ftf_pkg::REQ_PKT && s_tlast) || req == ftf_pkg::REQ_RD);
	assign done     = tok[FLOW_ENTRIES].go;

	// Header parser
	ftf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept && req == ftf_pkg::REQ_PKT),
		.last      (s_tlast),
		.data_byte (s_tdata[7:0]),
		.outer_vid (s_tdata[19:8]),
		.dec       (dec)
	);

	// Table maintenance goes to all cells at once
	assign cmd.wr   = accept && req == ftf_pkg::REQ_WR;
	assign cmd.inv  = accept && req == ftf_pkg::REQ_INV;
	assign cmd.idx  = s_tdata[25:20];
	assign cmd.sel  = s_tdata[28:26];
	assign cmd.word = s_tdata[92:29];

	// Hold the operation for the token's walk
	always_ff @(posedge clk) begin
		if (launch) begin
			job_q.idx <= s_tdata[25:20];
			if (req == ftf_pkg::REQ_RD) begin
				job_q.lookup  <= 1'b0;
				job_q.read    <= 1'b1;
				job_q.verdict <= ftf_pkg::VERDICT_ACCEPT;
				job_q.len     <= '0;
				job_q.key     <= '0;
			end else begin
				job_q.lookup  <= dec.lookup;
				job_q.read    <= 1'b0;
				job_q.verdict <= dec.verdict;
				job_q.len     <= dec.len;
				job_q.key     <= dec.key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q   <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			go_q <= launch;
			if (launch) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Cell row
	assign tok[0] = '{go: go_q, hit: 1'b0, hit_idx: '0, pkt: '0, byt: '0};

	for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
		ftf_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.job     (job_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_kind_q <= job_q.read;
			if (job_q.read) begin
				out_verdict_q <= ftf_pkg::VERDICT_ACCEPT;
			end else if (job_q.lookup) begin
				out_verdict_q <= tok[FLOW_ENTRIES].hit ? ftf_pkg::VERDICT_DROP
					: ftf_pkg::VERDICT_ACCEPT;
			end else begin
				out_verdict_q <= job_q.verdict;
			end
			out_hit_q <= tok[FLOW_ENTRIES].hit ? tok[FLOW_ENTRIES].hit_idx : 6'd0;
			out_pkt_q <= job_q.read ? tok[FLOW_ENTRIES].pkt : 64'd0;
			out_byt_q <= job_q.read ? tok[FLOW_ENTRIES].byt : 64'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {out_byt_q, out_pkt_q, out_hit_q, out_verdict_q};

`ifndef NO_ASSERTIONS
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n) go_q |-> busy_q)
		else $error("token launched while not busy");
	a_launch_go: assert property (@(posedge clk) disable iff (!arst_n) launch |=> go_q && busy_q)
		else $error("launch did not start a token");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n) done |=> out_valid_q)
		else $error("finished token did not reach the output");
	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		tok[FLOW_ENTRIES].hit |-> tok[FLOW_ENTRIES].go && job_q.lookup)
		else $error("hit without a lookup token");
`endif

endmodule
